// ===== rtl/qpd_pkg.sv =====
// Shared types, character codes and helper functions for the quoted-printable decoder.
`timescale 1ns / 1ps

package qpd_pkg;

  // Character codes used by the decoder
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  // Most output bytes kept for one input byte; grp_push drops any beyond
  localparam int unsigned MaxOut = 3;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);
  localparam int unsigned IdxW   = $clog2(MaxOut);

  // Escape tracking, one-hot
  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhEq    = 4'b0010,
    PhEqCr  = 4'b0100,
    PhEqHex = 4'b1000
  } phase_e;

  // Group of output bytes produced by one input byte
  typedef struct packed {
    logic [CntW-1:0]          n;     // number of results, 0 means none
    logic [MaxOut-1:0][7:0]   data;  // bytes in emit order, entry 0 first
    logic                     bare;  // single end marker without data
    logic                     last;  // group closes the message
  } qpd_group_t;

  // Digit value to uppercase hex character
  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = CharUpA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  // Uppercase hex character to value; bit 4 flags a valid digit
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] r;
    logic [7:0] t;
    r = 5'd0;
    if (b >= CharZero && b <= CharNine) begin
      t = b - CharZero;
      r = {1'b1, t[3:0]};
    end else if (b >= CharUpA && b <= CharUpF) begin
      t = b - CharUpA + 8'd10;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

  // Append one byte to a group; extra bytes past the limit are dropped
  function automatic qpd_group_t grp_push(qpd_group_t g, logic [7:0] b);
    qpd_group_t r;
    r = g;
    if (g.n < CntW'(MaxOut)) begin
      r.data[g.n[IdxW-1:0]] = b;
      r.n = g.n + CntW'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/qpd_decode.sv =====
// Escape state and per-byte decode logic of the quoted-printable decoder.
`timescale 1ns / 1ps

module qpd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic                advance_i,
  output qpd_pkg::qpd_group_t grp_o
);
  import qpd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] held_q, held_d;

  always_comb begin
    qpd_group_t g;
    logic [4:0] hv;
    logic       do_idle;
    g       = '0;
    hv      = hex_value(byte_i);
    do_idle = 1'b0;
    phase_d = PhIdle;
    held_d  = held_q;

    // Step the escape sequence
    case (phase_q)
      PhIdle: begin
        do_idle = 1'b1;
      end
      PhEq: begin
        if (byte_i == CharCr) begin
          phase_d = PhEqCr;
        end else if (byte_i == CharLf) begin
          phase_d = PhIdle;
        end else if (hv[4]) begin
          held_d  = hv[3:0];
          phase_d = PhEqHex;
        end else begin
          g       = grp_push(g, CharEq);
          do_idle = 1'b1;
        end
      end
      PhEqCr: begin
        if (byte_i != CharLf) begin
          g       = grp_push(g, CharEq);
          g       = grp_push(g, CharCr);
          do_idle = 1'b1;
        end
      end
      PhEqHex: begin
        if (hv[4]) begin
          g = grp_push(g, {held_q, hv[3:0]});
        end else begin
          g       = grp_push(g, CharEq);
          g       = grp_push(g, hex_char(held_q));
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Byte handled as ordinary text
    if (do_idle) begin
      if (byte_i == CharEq) begin
        phase_d = PhEq;
      end else if (byte_i == CharUnder) begin
        g = grp_push(g, CharSpace);
      end else begin
        g = grp_push(g, byte_i);
      end
    end

    // End of message: flush a pending escape literally
    if (last_i) begin
      case (phase_d)
        PhEq: begin
          g = grp_push(g, CharEq);
        end
        PhEqCr: begin
          g = grp_push(g, CharEq);
          g = grp_push(g, CharCr);
        end
        PhEqHex: begin
          g = grp_push(g, CharEq);
          g = grp_push(g, hex_char(held_d));
        end
        default: begin
        end
      endcase
      phase_d = PhIdle;
      held_d  = 4'd0;
      if (g.n == '0) begin
        g.n    = CntW'(1);
        g.bare = 1'b1;
      end
    end

    g.last = last_i;
    grp_o  = g;
  end

  // Escape state register, updated as each request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 4'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== rtl/qpd_out_buf.sv =====
// Result register that holds one decoded group and sends its bytes one per cycle while m_axis_tready is high.
`timescale 1ns / 1ps

module qpd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  qpd_pkg::qpd_group_t grp_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]          m_axis_tuser,  // [0] byte_valid, [1] run_last
  output logic                m_axis_tlast   // message_end
);
  import qpd_pkg::*;

  logic                   valid_q;
  logic [CntW-1:0]        n_q;
  logic [IdxW-1:0]        idx_q;
  logic [MaxOut-1:0][7:0] data_q;
  logic                   bare_q;
  logic                   last_q;
  logic                   final_entry;
  logic                   take;

  assign final_entry = (CntW'(idx_q) + CntW'(1)) == n_q;
  assign take        = valid_q && m_axis_tready;
  assign free_o      = !valid_q || (m_axis_tready && final_entry);

  // Control: fill on load, step through entries on each taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      n_q     <= '0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      n_q     <= grp_i.n;
      idx_q   <= '0;
    end else if (take) begin
      if (final_entry) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= grp_i.data;
      bare_q <= grp_i.bare;
      last_q <= grp_i.last;
    end
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = bare_q ? 8'd0 : data_q[idx_q];
  assign m_axis_tuser[0] = !bare_q;
  assign m_axis_tuser[1] = final_entry;
  assign m_axis_tlast    = final_entry && last_q;

  // A held group always has at least one entry and the index stays inside it
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (n_q != '0) && (CntW'(idx_q) < n_q))
    else $error("output index outside held group");

  // An end marker without data is a group of one
  a_bare_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && bare_q) |-> (n_q == CntW'(1)) && last_q)
    else $error("bare end marker in a group larger than one");

  // No new group overwrites bytes that are still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded while previous group still pending");

endmodule

// ===== rtl/quoted_printable_decoder.sv =====
// Top level of the streaming quoted-printable decoder.
`timescale 1ns / 1ps

// Streaming quoted-printable decoder. Encoded bytes enter on the s_axis side,
// tlast marking the final byte of a message; decoded bytes leave on m_axis,
// tlast marking the final result of the message. tuser[0] is low only on the
// bare end marker sent when the final byte produces no data, and tuser[1]
// flags the last result caused by one input byte. Each input byte passes an
// input register, then the decode logic loads its zero to three results into
// the result register together. With m_axis_tready high the output sends one
// result per cycle, a multi-result byte holds the result register until all
// are sent, and bytes with one or zero results sustain one byte per cycle.
// The input register ready depends combinationally on m_axis_tready.
module quoted_printable_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] run_last
  output logic       m_axis_tlast    // message_end
);
  import qpd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       load;
  logic       out_free;
  qpd_group_t grp;

  // Request moves on when it needs no result slot or the slot frees up
  assign advance       = in_valid_q && ((grp.n == '0) || out_free);
  assign load          = advance && (grp.n != '0);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  qpd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .advance_i (advance),
    .grp_o     (grp)
  );

  qpd_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .grp_i         (grp),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
